FILE: hw/rtl/command_frame_receiver_decoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the command frame receiver and decoder
// Shared wrappers for concurrent assertions clocked on the rising edge.
// ---------------------------------------------------------------------------
`ifndef COMMAND_FRAME_RECEIVER_DECODER_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_DECODER_ASSERT_SVH

// Condition holds at every edge outside reset.
`define CFRD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("cfrd: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define CFRD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfrd: implication violated");

`endif

FILE: hw/rtl/cfrd_pkg.sv
// ---------------------------------------------------------------------------
// cfrd_pkg
// Types, codes and default sizes for the command frame receiver and decoder.
// ---------------------------------------------------------------------------
package cfrd_pkg;

   localparam int MSG_DEPTH_DEF     = 64;
   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int NAME_CHARS_DEF    = 16;

   localparam logic [2:0] STATUS_IDLE     = 3'd0;
   localparam logic [2:0] STATUS_BUSY     = 3'd1;
   localparam logic [2:0] STATUS_MATCH    = 3'd2;
   localparam logic [2:0] STATUS_UNKNOWN  = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd4;
   localparam logic [2:0] STATUS_EMPTY    = 3'd5;

   localparam logic [1:0] CSR_START_CHAR    = 2'd0;
   localparam logic [1:0] CSR_END_CHAR      = 2'd1;
   localparam logic [1:0] CSR_SEPARATOR     = 2'd2;
   localparam logic [1:0] CSR_COMMAND_COUNT = 2'd3;

   localparam logic [7:0] START_CHAR_RESET    = 8'd58;
   localparam logic [7:0] END_CHAR_RESET      = 8'd10;
   localparam logic [7:0] SEPARATOR_RESET     = 8'd32;
   localparam logic [4:0] COMMAND_COUNT_RESET = 5'd0;

   localparam logic       FUNC_STREAM = 1'b0;
   localparam logic [7:0] NAME_TERMINATOR = 8'd0;

   typedef enum logic [1:0] {
      ST_READY,
      ST_FETCH,
      ST_COMPARE
   } state_type;

endpackage

FILE: hw/rtl/cfrd_ram.sv
// ---------------------------------------------------------------------------
// cfrd_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module cfrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/command_frame_receiver_decoder.sv
// ---------------------------------------------------------------------------
// command_frame_receiver_decoder
// Frames a byte stream into command messages and looks the command name up
// in a loaded table of zero-terminated names.
// ---------------------------------------------------------------------------
// Every request beat gives exactly one response beat. Table writes, idle
// bytes, frame start, stored bytes, overflow and empty frames are answered
// without a search. An end character that closes a non-empty frame that is
// not full, while the command count is nonzero, starts a table search that
// walks the entries in order through the single read port of the name table
// and message memories, with a FETCH and a COMPARE state per compared
// character and per entry; request tready is low during the search.
// ---------------------------------------------------------------------------
`include "command_frame_receiver_decoder_assert.svh"

module command_frame_receiver_decoder #(
   parameter int MSG_DEPTH     = cfrd_pkg::MSG_DEPTH_DEF,
   parameter int TABLE_ENTRIES = cfrd_pkg::TABLE_ENTRIES_DEF,
   parameter int NAME_CHARS    = cfrd_pkg::NAME_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_byte [7:0], entry_index [11:8], char_position [15:12]
   input  logic [15:0] req_tdata,
   // func [0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status [2:0], command_index [6:3], name_length [13:7],
   // message_length [20:14], zero [23:21]
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int MCW = $clog2(MSG_DEPTH + 1);
   localparam int MAW = $clog2(MSG_DEPTH);
   localparam int PW  = $clog2(NAME_CHARS + 1);
   localparam int CW  = (PW > MCW) ? PW : MCW;
   localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ECW = EW + 1;
   localparam int TAW = $clog2(TABLE_ENTRIES * NAME_CHARS);

   logic [7:0] start_char_ff;
   logic [7:0] end_char_ff;
   logic [7:0] separator_ff;
   logic [4:0] command_count_ff;

   cfrd_pkg::state_type state_ff, state_in;
   logic           receiving_ff, receiving_in;
   logic [MCW-1:0] stored_count_ff, stored_count_in;
   logic [MCW-1:0] name_end_ff, name_end_in;
   logic           separator_seen_ff, separator_seen_in;
   logic [ECW-1:0] entry_ff, entry_in;
   logic [PW-1:0]  pos_ff, pos_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [3:0] rsp_index_ff, rsp_index_in;
   logic [6:0] rsp_name_len_ff, rsp_name_len_in;
   logic [6:0] rsp_msg_len_ff, rsp_msg_len_in;

   logic           in_func;
   logic [7:0]     in_byte;
   logic [3:0]     in_entry;
   logic [3:0]     in_pos;
   logic           accept;
   logic [ECW-1:0] limit;
   logic [CW-1:0]  pos_ext;
   logic [CW-1:0]  name_end_ext;
   logic           at_name_end;
   logic           pos_at_width;

   logic           msg_we;
   logic [MAW-1:0] msg_raddr;
   logic [7:0]     msg_rdata;
   logic           tbl_we;
   logic [TAW-1:0] tbl_waddr;
   logic [TAW-1:0] tbl_raddr;
   logic [7:0]     tbl_rdata;

   assign in_func  = req_tuser;
   assign in_byte  = req_tdata[7:0];
   assign in_entry = req_tdata[11:8];
   assign in_pos   = req_tdata[15:12];

   assign req_tready = (state_ff == cfrd_pkg::ST_READY) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign limit = (int'(command_count_ff) > TABLE_ENTRIES) ? ECW'(TABLE_ENTRIES)
                                                           : ECW'(command_count_ff);

   assign pos_ext      = CW'(pos_ff);
   assign name_end_ext = CW'(name_end_ff);
   assign at_name_end  = (pos_ext == name_end_ext);
   assign pos_at_width = (pos_ext == CW'(NAME_CHARS));

   assign msg_raddr = MAW'(pos_ff);
   assign tbl_waddr = TAW'(int'(in_entry) * NAME_CHARS + int'(in_pos));
   assign tbl_raddr = (int'(pos_ff) < NAME_CHARS)
                    ? TAW'(int'(entry_ff) * NAME_CHARS + int'(pos_ff)) : '0;

   cfrd_ram #(
      .WIDTH (8),
      .DEPTH (MSG_DEPTH)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (msg_we),
      .wr_addr (MAW'(stored_count_ff)),
      .wr_data (in_byte),
      .rd_addr (msg_raddr),
      .rd_data (msg_rdata)
   );

   cfrd_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_ENTRIES * NAME_CHARS)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (in_byte),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff    <= cfrd_pkg::START_CHAR_RESET;
         end_char_ff      <= cfrd_pkg::END_CHAR_RESET;
         separator_ff     <= cfrd_pkg::SEPARATOR_RESET;
         command_count_ff <= cfrd_pkg::COMMAND_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cfrd_pkg::CSR_START_CHAR:    start_char_ff    <= csr_data;
            cfrd_pkg::CSR_END_CHAR:      end_char_ff      <= csr_data;
            cfrd_pkg::CSR_SEPARATOR:     separator_ff     <= csr_data;
            cfrd_pkg::CSR_COMMAND_COUNT: command_count_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= cfrd_pkg::ST_READY;
         receiving_ff      <= 1'b0;
         stored_count_ff   <= '0;
         name_end_ff       <= '0;
         separator_seen_ff <= 1'b0;
         entry_ff          <= '0;
         pos_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         receiving_ff      <= receiving_in;
         stored_count_ff   <= stored_count_in;
         name_end_ff       <= name_end_in;
         separator_seen_ff <= separator_seen_in;
         entry_ff          <= entry_in;
         pos_ff            <= pos_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_name_len_ff <= rsp_name_len_in;
      rsp_msg_len_ff  <= rsp_msg_len_in;
   end

   always_comb begin
      state_in          = state_ff;
      receiving_in      = receiving_ff;
      stored_count_in   = stored_count_ff;
      name_end_in       = name_end_ff;
      separator_seen_in = separator_seen_ff;
      entry_in          = entry_ff;
      pos_in            = pos_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_status_in     = rsp_status_ff;
      rsp_index_in      = rsp_index_ff;
      rsp_name_len_in   = rsp_name_len_ff;
      rsp_msg_len_in    = rsp_msg_len_ff;
      msg_we            = 1'b0;
      tbl_we            = 1'b0;

      unique case (state_ff)
         cfrd_pkg::ST_READY: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               if (in_func != cfrd_pkg::FUNC_STREAM) begin
                  tbl_we = (int'(in_entry) < TABLE_ENTRIES) && (int'(in_pos) < NAME_CHARS);
                  rsp_status_in = receiving_ff ? cfrd_pkg::STATUS_BUSY
                                               : cfrd_pkg::STATUS_IDLE;
               end else if (!receiving_ff) begin
                  if (in_byte == start_char_ff) begin
                     receiving_in      = 1'b1;
                     stored_count_in   = '0;
                     name_end_in       = '0;
                     separator_seen_in = 1'b0;
                     rsp_status_in     = cfrd_pkg::STATUS_BUSY;
                  end else begin
                     rsp_status_in = cfrd_pkg::STATUS_IDLE;
                  end
               end else if (int'(stored_count_ff) == MSG_DEPTH) begin
                  receiving_in  = 1'b0;
                  rsp_status_in = cfrd_pkg::STATUS_OVERFLOW;
               end else if (in_byte == end_char_ff) begin
                  receiving_in = 1'b0;
                  if (stored_count_ff == '0) begin
                     rsp_status_in = cfrd_pkg::STATUS_EMPTY;
                  end else if (limit == '0) begin
                     rsp_status_in = cfrd_pkg::STATUS_UNKNOWN;
                  end else begin
                     rsp_valid_in = 1'b0;
                     entry_in     = '0;
                     pos_in       = '0;
                     state_in     = cfrd_pkg::ST_FETCH;
                  end
               end else begin
                  msg_we            = 1'b1;
                  stored_count_in   = stored_count_ff + MCW'(1);
                  separator_seen_in = separator_seen_ff || (in_byte == separator_ff);
                  if (!separator_seen_in) begin
                     name_end_in = stored_count_in;
                  end
                  rsp_status_in = cfrd_pkg::STATUS_BUSY;
               end
               rsp_name_len_in = 7'(name_end_in);
               rsp_msg_len_in  = 7'(stored_count_in);
            end
         end
         cfrd_pkg::ST_FETCH: begin
            state_in = cfrd_pkg::ST_COMPARE;
         end
         cfrd_pkg::ST_COMPARE: begin
            if (at_name_end && (pos_at_width || tbl_rdata == cfrd_pkg::NAME_TERMINATOR)) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = cfrd_pkg::STATUS_MATCH;
               rsp_index_in    = 4'(entry_ff);
               rsp_name_len_in = 7'(name_end_ff);
               rsp_msg_len_in  = 7'(stored_count_ff);
               state_in        = cfrd_pkg::ST_READY;
            end else if (at_name_end || pos_at_width
                         || tbl_rdata == cfrd_pkg::NAME_TERMINATOR
                         || tbl_rdata != msg_rdata) begin
               if (entry_ff + ECW'(1) == limit) begin
                  rsp_valid_in    = 1'b1;
                  rsp_status_in   = cfrd_pkg::STATUS_UNKNOWN;
                  rsp_index_in    = '0;
                  rsp_name_len_in = 7'(name_end_ff);
                  rsp_msg_len_in  = 7'(stored_count_ff);
                  state_in        = cfrd_pkg::ST_READY;
               end else begin
                  entry_in = entry_ff + ECW'(1);
                  pos_in   = '0;
                  state_in = cfrd_pkg::ST_FETCH;
               end
            end else begin
               pos_in   = pos_ff + PW'(1);
               state_in = cfrd_pkg::ST_FETCH;
            end
         end
         default: begin
            state_in = cfrd_pkg::ST_READY;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_msg_len_ff, rsp_name_len_ff, rsp_index_ff, rsp_status_ff};

   `CFRD_ASSERT_IMPLIES(a_no_rsp_while_searching, clock, reset, state_ff != cfrd_pkg::ST_READY, !rsp_valid_ff && !receiving_ff)
   `CFRD_ASSERT_IMPLIES(a_search_within_name, clock, reset, state_ff != cfrd_pkg::ST_READY, pos_ext <= name_end_ext && entry_ff < limit)
   `CFRD_ASSERT_ALWAYS(a_lengths_bounded, clock, reset, name_end_ff <= stored_count_ff && int'(stored_count_ff) <= MSG_DEPTH)

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the command frame receiver and decoder
// Loads the name table, runs directed frames, then random frames under
// several register settings and flow-control phases. Every response beat is
// checked field by field against a behavioral predictor.
// ---------------------------------------------------------------------------
module tb;

   localparam int MSG_DEPTH     = cfrd_pkg::MSG_DEPTH_DEF;
   localparam int TABLE_ENTRIES = cfrd_pkg::TABLE_ENTRIES_DEF;
   localparam int NAME_CHARS    = cfrd_pkg::NAME_CHARS_DEF;

   localparam logic FUNC_TABLE_WRITE = 1'b1;
   localparam int   STALL_LIMIT      = 20000;
   localparam int   HOLD_CYCLES      = 300;
   localparam int   PHASE_COUNT      = 8;
   localparam int   PHASE_ITEMS      = 70;

   typedef struct packed {
      logic [6:0] msg_len;
      logic [6:0] name_len;
      logic [3:0] cmd;
      logic [2:0] status;
   } reply_type;

   class frame_checker;
      logic [7:0] start_ch;
      logic [7:0] end_ch;
      logic [7:0] sep_ch;
      logic [4:0] cmd_count;
      bit         receiving;
      bit         sep_seen;
      int         stored;
      int         name_end;
      logic [7:0] msg_buf [MSG_DEPTH];
      logic [7:0] name_table [TABLE_ENTRIES][NAME_CHARS];
      reply_type  pending_replies [$];
      int         errors;

      function new();
         start_ch  = cfrd_pkg::START_CHAR_RESET;
         end_ch    = cfrd_pkg::END_CHAR_RESET;
         sep_ch    = cfrd_pkg::SEPARATOR_RESET;
         cmd_count = cfrd_pkg::COMMAND_COUNT_RESET;
         receiving = 1'b0;
         sep_seen  = 1'b0;
         stored    = 0;
         name_end  = 0;
         errors    = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [7:0] val);
         case (idx)
            cfrd_pkg::CSR_START_CHAR:    start_ch = val;
            cfrd_pkg::CSR_END_CHAR:      end_ch = val;
            cfrd_pkg::CSR_SEPARATOR:     sep_ch = val;
            cfrd_pkg::CSR_COMMAND_COUNT: cmd_count = val[4:0];
            default: ;
         endcase
      endfunction

      function int entry_len(int e);
         int n;
         n = 0;
         while (n < NAME_CHARS && name_table[e][n] != cfrd_pkg::NAME_TERMINATOR)
            n++;
         return n;
      endfunction

      function int lookup_command();
         int  limit;
         bit  same;
         limit = (cmd_count > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cmd_count);
         for (int k = 0; k < limit; k++) begin
            if (entry_len(k) == name_end) begin
               same = 1'b1;
               for (int c = 0; c < name_end; c++) begin
                  if (name_table[k][c] != msg_buf[c])
                     same = 1'b0;
               end
               if (same)
                  return k;
            end
         end
         return -1;
      endfunction

      function void note_request(logic f, logic [7:0] b, logic [3:0] e, logic [3:0] p);
         reply_type r;
         int        hit;
         r = '0;
         if (f == FUNC_TABLE_WRITE) begin
            if (int'(e) < TABLE_ENTRIES && int'(p) < NAME_CHARS)
               name_table[e][p] = b;
            r.status = receiving ? cfrd_pkg::STATUS_BUSY : cfrd_pkg::STATUS_IDLE;
         end else if (!receiving) begin
            if (b == start_ch) begin
               receiving = 1'b1;
               stored    = 0;
               name_end  = 0;
               sep_seen  = 1'b0;
               r.status  = cfrd_pkg::STATUS_BUSY;
            end else begin
               r.status = cfrd_pkg::STATUS_IDLE;
            end
         end else if (stored >= MSG_DEPTH) begin
            receiving = 1'b0;
            r.status  = cfrd_pkg::STATUS_OVERFLOW;
         end else if (b == end_ch) begin
            receiving = 1'b0;
            if (stored == 0) begin
               r.status = cfrd_pkg::STATUS_EMPTY;
            end else begin
               hit = lookup_command();
               if (hit >= 0) begin
                  r.status = cfrd_pkg::STATUS_MATCH;
                  r.cmd    = 4'(hit);
               end else begin
                  r.status = cfrd_pkg::STATUS_UNKNOWN;
               end
            end
         end else begin
            msg_buf[stored] = b;
            stored++;
            if (b == sep_ch)
               sep_seen = 1'b1;
            if (!sep_seen)
               name_end = stored;
            r.status = cfrd_pkg::STATUS_BUSY;
         end
         r.name_len = 7'(name_end);
         r.msg_len  = 7'(stored);
         pending_replies.push_back(r);
      endfunction

      function void check_reply(logic [23:0] bits);
         reply_type got;
         reply_type want;
         got = bits[20:0];
         if (pending_replies.size() == 0) begin
            $error("response beat %h with no request outstanding", bits);
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.cmd !== want.cmd) begin
            $error("command_index: expected %0d, actual %0d", want.cmd, got.cmd);
            errors++;
         end
         if (got.name_len !== want.name_len) begin
            $error("name_length: expected %0d, actual %0d", want.name_len, got.name_len);
            errors++;
         end
         if (got.msg_len !== want.msg_len) begin
            $error("message_length: expected %0d, actual %0d", want.msg_len, got.msg_len);
            errors++;
         end
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   frame_checker board;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int holds_asked = 0;
   int items_sent = 0;
   int quiet_cycles = 0;

   command_frame_receiver_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'($urandom_range(8'h61, 8'h7a));
   endfunction

   function automatic logic [7:0] non_letter();
      logic [7:0] v;
      do
         v = any_byte();
      while (v >= 8'h61 && v <= 8'h7a);
      return v;
   endfunction

   function automatic logic [7:0] non_end_byte();
      logic [7:0] v;
      do
         v = any_byte();
      while (v == board.end_ch);
      return v;
   endfunction

   task automatic send_item(input logic f, input logic [7:0] b, input logic [3:0] e,
                            input logic [3:0] p);
      items_sent++;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {p, e, b};
      do
         @(posedge clock);
      while (!req_tready);
      board.note_request(f, b, e, p);
   endtask

   task automatic push_stream(input logic [7:0] b);
      send_item(cfrd_pkg::FUNC_STREAM, b, 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)));
   endtask

   task automatic push_args(input int n);
      repeat (n) push_stream(non_end_byte());
   endtask

   task automatic send_name(input int e);
      int len;
      len = board.entry_len(e);
      for (int c = 0; c < len; c++)
         push_stream(board.name_table[e][c]);
   endtask

   task automatic random_table_write();
      int         pick;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         b = rand_letter();
      else if (pick < 75)
         b = cfrd_pkg::NAME_TERMINATOR;
      else
         b = any_byte();
      send_item(FUNC_TABLE_WRITE, b, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do
         @(posedge clock);
      while (!csr_ready);
      board.write_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
         default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
   endtask

   task automatic apply_setting(input int phase);
      logic [7:0] s;
      logic [7:0] en;
      logic [7:0] sp;
      logic [7:0] cnt;
      do begin
         s  = non_letter();
         en = non_letter();
         sp = non_letter();
      end while (s == en || s == sp || en == sp);
      case (phase)
         0, 4: begin
            s  = cfrd_pkg::START_CHAR_RESET;
            en = cfrd_pkg::END_CHAR_RESET;
            sp = cfrd_pkg::SEPARATOR_RESET;
            cnt = 8'd16;
         end
         1: begin s = 8'h00; en = 8'hFF; sp = 8'h2C; cnt = 8'd31; end
         2: begin s = 8'hFF; en = 8'h00; sp = 8'h80; cnt = 8'd0; end
         3: cnt = 8'd17;
         5: cnt = 8'($urandom_range(1, 16));
         6: cnt = 8'd8;
         default: cnt = 8'd1;
      endcase
      write_csr(cfrd_pkg::CSR_START_CHAR, s);
      write_csr(cfrd_pkg::CSR_END_CHAR, en);
      write_csr(cfrd_pkg::CSR_SEPARATOR, sp);
      write_csr(cfrd_pkg::CSR_COMMAND_COUNT, cnt);
   endtask

   task automatic load_table();
      int         len;
      logic [7:0] b;
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
         len = $urandom_range(1, 8);
         if (e == 5)
            len = 0;
         else if (e == 7)
            len = NAME_CHARS;
         else if (e == 15)
            len = 1;
         for (int c = 0; c < NAME_CHARS; c++) begin
            if (e == 9)
               b = board.name_table[2][c];
            else if (c < len)
               b = rand_letter();
            else if (c == len)
               b = cfrd_pkg::NAME_TERMINATOR;
            else
               b = any_byte();
            send_item(FUNC_TABLE_WRITE, b, 4'(e), 4'(c));
         end
      end
   endtask

   task automatic send_random_frame();
      int kind;
      int limit;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 3) == 0)
               random_table_write();
            else
               push_stream(any_byte());
         end
         return;
      end
      push_stream(board.start_ch);
      if (kind < 60) begin
         limit = (board.cmd_count > TABLE_ENTRIES || board.cmd_count == 0) ?
                 TABLE_ENTRIES : int'(board.cmd_count);
         send_name($urandom_range(0, limit - 1));
         if ($urandom_range(0, 1) == 1) begin
            push_stream(board.sep_ch);
            push_args($urandom_range(0, 10));
         end
         push_stream(board.end_ch);
      end else if (kind < 72) begin
         repeat ($urandom_range(1, 8)) push_stream(rand_letter());
         if ($urandom_range(0, 1) == 1) begin
            push_stream(board.sep_ch);
            push_args($urandom_range(0, 6));
         end
         push_stream(board.end_ch);
      end else if (kind < 80) begin
         push_args($urandom_range(MSG_DEPTH - 2, MSG_DEPTH + 2));
         push_stream(($urandom_range(0, 1) == 1) ? board.end_ch : any_byte());
      end else if (kind < 86) begin
         push_stream(board.end_ch);
      end else begin
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0)
               random_table_write();
            else
               push_stream(any_byte());
         end
         if ($urandom_range(0, 1) == 1)
            push_stream(board.end_ch);
      end
   endtask

   initial begin : receiver
      int hold_left;
      int holds_done;
      hold_left = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_reply(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int target;
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_table();

      // With the power-on settings no entry is searched.
      push_stream(8'hFF);
      push_stream(board.start_ch);
      push_stream(board.end_ch);
      push_stream(board.start_ch);
      send_name(15);
      push_stream(board.end_ch);
      drain();

      write_csr(cfrd_pkg::CSR_COMMAND_COUNT, 8'd16);
      send_item(FUNC_TABLE_WRITE, 8'h71, 4'd15, 4'd0);
      push_stream(board.start_ch);
      send_name(15);
      push_stream(board.end_ch);
      push_stream(board.start_ch);
      push_stream(board.sep_ch);
      push_stream(8'h78);
      push_stream(board.end_ch);
      push_stream(board.start_ch);
      send_name(9);
      push_stream(board.end_ch);
      push_stream(board.start_ch);
      send_item(FUNC_TABLE_WRITE, 8'h71, 4'd15, 4'd0);
      send_name(15);
      push_stream(board.end_ch);
      push_stream(board.start_ch);
      push_stream(8'h71);
      push_stream(8'h71);
      push_stream(board.end_ch);
      push_stream(board.start_ch);
      push_stream(board.start_ch);
      push_stream(board.end_ch);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         apply_setting(phase);
         set_idling(phase % 4);
         if (phase == 4)
            holds_asked++;
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target)
            send_random_frame();
      end
      drain();
      repeat (64) @(posedge clock);

      if (board.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cfrd_pkg.sv
hw/rtl/cfrd_ram.sv
hw/rtl/command_frame_receiver_decoder.sv
bench/tb.sv
